// ===== design/lpi_pkg.sv =====
`default_nettype none

package lpi_pkg;

  // point and coefficient formats
  localparam int PW   = 16;       // point coordinate, Q8.8
  localparam int CW   = 32;       // matrix coefficient, Q16.16
  localparam int PRW  = PW + CW;  // coefficient times coordinate, Q.24
  localparam int SW   = PRW + 1;  // row sum, Q.24
  localparam int MW   = SW;       // magnitude of a row sum
  localparam int FRAC = 8;        // pixel fraction bits
  localparam int NW   = MW + FRAC;  // numerator magnitude after scaling
  localparam int QW   = 24;       // pixel width, one divider step per bit
  localparam int TW   = MW + QW;  // trial subtract width

  // configuration port
  localparam int NREGS  = 6;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 2 * CW;

  localparam logic [CFG_IW-1:0] REG_R0_C01 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_R0_C23 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_R1_C01 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_R1_C23 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_R2_C01 = 3'd4;
  localparam logic [CFG_IW-1:0] REG_R2_C23 = 3'd5;

  // saturation bounds
  localparam logic [QW-1:0] PIX_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] PIX_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic              we;
    logic [CFG_IW-1:0] idx;
    logic [CFG_DW-1:0] data;
  } cfg_wr_t;

  // one classified point, as queued between front and back
  typedef struct packed {
    logic [MW-1:0] mag_a;
    logic [MW-1:0] mag_b;
    logic [MW-1:0] mag_c;
    logic          neg_u;
    logic          neg_v;
    logic          zero;
    logic          last;
  } proj_ent_t;

  // per-point information carried along the divider stages
  typedef struct packed {
    logic [MW-1:0] den;
    logic          neg_u;
    logic          neg_v;
    logic          zero;
    logic          last;
  } div_side_t;

  // partial remainder and quotient of one divider lane
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
  } div_lane_t;

  // one restoring step: test den << sh against the remainder
  function automatic div_lane_t div_step(div_lane_t cur, logic [MW-1:0] den,
                                         int unsigned sh);
    logic [TW-1:0] num_ext;
    logic [TW-1:0] den_sh;
    logic [TW-1:0] diff;
    logic          ge;
    div_lane_t     nxt;
    num_ext = TW'(cur.rem);
    den_sh  = TW'(den) << sh;
    diff    = num_ext - den_sh;
    ge      = (num_ext >= den_sh);
    nxt.rem = ge ? diff[NW-1:0] : cur.rem;
    nxt.quo = {cur.quo[QW-2:0], ge};
    return nxt;
  endfunction

  // magnitude of a signed row sum
  function automatic logic [MW-1:0] abs_sum(logic signed [SW-1:0] s);
    return s[SW-1] ? MW'(-s) : MW'(s);
  endfunction

endpackage

`default_nettype wire

// ===== design/lpi_front.sv =====
`default_nettype none

module lpi_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lpi_pkg::cfg_wr_t    cfg_wr,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [15:0]  in_point_x,
  input  wire logic signed [15:0]  in_point_y,
  input  wire logic signed [15:0]  in_point_z,
  input  wire logic                in_last_point,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output lpi_pkg::proj_ent_t       push_ent
);
  import lpi_pkg::*;

  logic [CFG_DW-1:0] coef_r [NREGS];

  logic signed [CW-1:0] kx [3];
  logic signed [CW-1:0] ky [3];
  logic signed [CW-1:0] kz [3];
  logic signed [CW-1:0] ko [3];

  logic signed [PRW-1:0] prod_x_r [3];
  logic signed [PRW-1:0] prod_y_r [3];
  logic signed [PRW-1:0] prod_z_r [3];
  logic signed [SW-1:0]  sum_r [3];
  logic                  last1_r;
  logic                  last2_r;
  logic                  v1_r;
  logic                  v2_r;
  logic                  v3_r;
  proj_ent_t             ent_r;
  proj_ent_t             ent_nxt;
  logic                  en;

  // coefficient registers, writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr.we && (cfg_wr.idx < CFG_IW'(NREGS))) begin
      coef_r[cfg_wr.idx] <= cfg_wr.data;
    end
  end

  // unpack two Q16.16 coefficients per register
  for (genvar r = 0; r < 3; r++) begin : g_coef
    assign kx[r] = coef_r[2*r][CW-1:0];
    assign ky[r] = coef_r[2*r][CFG_DW-1:CW];
    assign kz[r] = coef_r[2*r+1][CW-1:0];
    assign ko[r] = coef_r[2*r+1][CFG_DW-1:CW];
  end

  // the whole front moves together, stalling only on a full queue
  assign en       = !v3_r || push_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_x_r[r] <= kx[r] * in_point_x;
        prod_y_r[r] <= ky[r] * in_point_y;
        prod_z_r[r] <= kz[r] * in_point_z;
      end
      last1_r <= in_last_point;
    end
  end

  // stage 2: row sums with the offset aligned to Q.24
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= SW'(prod_x_r[r]) + SW'(prod_y_r[r]) + SW'(prod_z_r[r])
                    + (SW'(ko[r]) <<< FRAC);
      end
      last2_r <= last1_r;
    end
  end

  // stage 3: signs, magnitudes and zero depth
  always_comb begin
    ent_nxt.mag_a = abs_sum(sum_r[0]);
    ent_nxt.mag_b = abs_sum(sum_r[1]);
    ent_nxt.mag_c = abs_sum(sum_r[2]);
    ent_nxt.neg_u = sum_r[0][SW-1] ^ sum_r[2][SW-1];
    ent_nxt.neg_v = sum_r[1][SW-1] ^ sum_r[2][SW-1];
    ent_nxt.zero  = (sum_r[2] == '0);
    ent_nxt.last  = last2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign push_valid = v3_r;
  assign push_ent   = ent_r;

endmodule

`default_nettype wire

// ===== design/lpi_queue.sv =====
`default_nettype none

module lpi_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire lpi_pkg::proj_ent_t  push_ent,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output lpi_pkg::proj_ent_t       pop_ent
);
  import lpi_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  proj_ent_t       mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic [PTRW-1:0] wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_nxt;
  logic [CNTW-1:0] cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != CNTW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_ent    = mem_r[rd_ptr_r];

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

`default_nettype wire

// ===== design/lpi_back.sv =====
`default_nettype none

module lpi_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire lpi_pkg::proj_ent_t  pop_ent,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [23:0]       out_pixel_u,
  output logic signed [23:0]       out_pixel_v,
  output logic                     out_depth_zero,
  output logic                     out_last_result
);
  import lpi_pkg::*;

  div_lane_t   lane_u_r [QW];
  div_lane_t   lane_v_r [QW];
  div_side_t   side_r [QW];
  logic [QW-1:0] vld_r;
  div_lane_t   init_u;
  div_lane_t   init_v;
  div_side_t   side_in;
  logic        adv;
  logic        out_valid_r;
  logic [QW-1:0] pix_u_r;
  logic [QW-1:0] pix_v_r;
  logic        zero_r;
  logic        last_r;
  logic [QW-1:0] pix_u_nxt;
  logic [QW-1:0] pix_v_nxt;

  // divider stages move whenever the output register can take a result
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;

  // numerators scaled to Q.8 of the quotient
  assign init_u  = '{rem: {pop_ent.mag_a, {FRAC{1'b0}}}, quo: '0};
  assign init_v  = '{rem: {pop_ent.mag_b, {FRAC{1'b0}}}, quo: '0};
  assign side_in = '{den: pop_ent.mag_c, neg_u: pop_ent.neg_u,
                     neg_v: pop_ent.neg_v, zero: pop_ent.zero, last: pop_ent.last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QW-2:0], pop_valid};
    end
  end

  // stage 0 resolves the top quotient bit straight from the queue head
  always_ff @(posedge clk) begin
    if (adv) begin
      lane_u_r[0] <= div_step(init_u, side_in.den, QW - 1);
      lane_v_r[0] <= div_step(init_v, side_in.den, QW - 1);
      side_r[0]   <= side_in;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 1; j < QW; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        lane_u_r[j] <= div_step(lane_u_r[j-1], side_r[j-1].den, QW - 1 - j);
        lane_v_r[j] <= div_step(lane_v_r[j-1], side_r[j-1].den, QW - 1 - j);
        side_r[j]   <= side_r[j-1];
      end
    end
  end

  // sign, saturation and zero depth; a set top bit means |q| >= 2^23
  always_comb begin
    if (side_r[QW-1].zero) begin
      pix_u_nxt = '0;
    end else if (lane_u_r[QW-1].quo[QW-1]) begin
      pix_u_nxt = side_r[QW-1].neg_u ? PIX_MIN : PIX_MAX;
    end else begin
      pix_u_nxt = side_r[QW-1].neg_u ? -lane_u_r[QW-1].quo : lane_u_r[QW-1].quo;
    end
    if (side_r[QW-1].zero) begin
      pix_v_nxt = '0;
    end else if (lane_v_r[QW-1].quo[QW-1]) begin
      pix_v_nxt = side_r[QW-1].neg_v ? PIX_MIN : PIX_MAX;
    end else begin
      pix_v_nxt = side_r[QW-1].neg_v ? -lane_v_r[QW-1].quo : lane_v_r[QW-1].quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_u_r <= pix_u_nxt;
      pix_v_r <= pix_v_nxt;
      zero_r  <= side_r[QW-1].zero;
      last_r  <= side_r[QW-1].last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_u     = pix_u_r;
  assign out_pixel_v     = pix_v_r;
  assign out_depth_zero  = zero_r;
  assign out_last_result = last_r;

endmodule

`default_nettype wire

// ===== design/lidar_point_to_image_projection.sv =====
`default_nettype none

// Projects lidar points through a 3x4 camera matrix into Q15.8 pixel
// coordinates, one point per clock sustained while neither side stalls.
// The front end registers the nine coefficient products, sums each row
// and splits the results into sign and magnitude; a small queue
// (QUEUE_DEPTH entries) then hands the points to a 24-stage pipelined
// restoring divider, one quotient bit per stage, with u and v divided side
// by side. A point passes through the three front stages, the queue, the
// 24 divider stages and the output register. Each side stalls on its own:
// a full queue holds off input, a stalled output freezes the divider.
// Coefficients are written through cfg_we/cfg_index/cfg_wdata, two Q16.16
// values per 64-bit register, and should only change while no points are
// in flight. A zero depth sets out_depth_zero with both coordinates zero.

module lidar_point_to_image_projection #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [lpi_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [lpi_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [15:0]         in_point_x,
  input  wire logic signed [15:0]         in_point_y,
  input  wire logic signed [15:0]         in_point_z,
  input  wire logic                       in_last_point,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [23:0]              out_pixel_u,
  output logic signed [23:0]              out_pixel_v,
  output logic                            out_depth_zero,
  output logic                            out_last_result
);
  import lpi_pkg::*;

  cfg_wr_t   cfg_wr;
  logic      push_valid;
  logic      push_ready;
  proj_ent_t push_ent;
  logic      pop_valid;
  logic      pop_ready;
  proj_ent_t pop_ent;

  assign cfg_wr = '{we: cfg_we, idx: cfg_index, data: cfg_wdata};

  lpi_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_last_point (in_last_point),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_ent      (push_ent)
  );

  lpi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ent   (push_ent),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ent    (pop_ent)
  );

  lpi_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_ent         (pop_ent),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_u     (out_pixel_u),
    .out_pixel_v     (out_pixel_v),
    .out_depth_zero  (out_depth_zero),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire

// ===== dv/lidar_point_to_image_projection_tb.sv =====
`timescale 1ns / 100ps

module lidar_point_to_image_projection_tb;
  import lpi_pkg::*;

  // coefficient set selectors, directed and random
  typedef enum logic [2:0] {
    MAT_RESET,
    MAT_UNIT,
    MAT_SATURATE,
    MAT_CAMERA,
    MAT_RANDOM,
    MAT_EXTREME,
    MAT_FLAT_DEPTH
  } matrix_kind_t;

  typedef struct packed {
    logic [23:0] u;
    logic [23:0] v;
    logic        zero;
    logic        last;
  } pix_res_t;

  typedef struct packed {
    matrix_kind_t mat;
    logic [15:0]  x;
    logic [15:0]  y;
    logic [15:0]  z;
    logic         last;
    logic         typed;
    logic [23:0]  u;
    logic [23:0]  v;
    logic         dz;
  } dir_row_t;

  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam longint      PIX_HI       = longint'($signed(PIX_MAX));
  localparam longint      PIX_LO       = longint'($signed(PIX_MIN));
  localparam int          PHASE_POINTS = 250;
  localparam int          NPHASE       = 6;
  localparam int          NDIR         = 19;

  localparam matrix_kind_t PHASE_KINDS [NPHASE] = '{
    MAT_CAMERA, MAT_RANDOM, MAT_EXTREME, MAT_FLAT_DEPTH, MAT_CAMERA, MAT_RANDOM
  };

  // directed points; u/v/dz are only meaningful where typed is set
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    // registers still at reset: depth is always zero
    '{MAT_RESET, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 24'h000000, 24'h000000, 1'b1},
    '{MAT_RESET, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 24'h000000, 24'h000000, 1'b1},
    '{MAT_RESET, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1, 24'h000000, 24'h000000, 1'b1},
    // unit matrix: u = x*256/z, v = y*256/z
    '{MAT_UNIT, 16'h0100, 16'hFE00, 16'h0100, 1'b0, 1'b1, 24'h000100, 24'hFFFE00, 1'b0},
    '{MAT_UNIT, 16'h0064, 16'h00C8, 16'h0000, 1'b1, 1'b1, 24'h000000, 24'h000000, 1'b1},
    '{MAT_UNIT, 16'h8000, 16'h7FFF, 16'h0001, 1'b0, 1'b1, 24'h800000, 24'h7FFF00, 1'b0},
    // negative depth, u or v clips high
    '{MAT_UNIT, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b1, 24'h800100, 24'h7FFFFF, 1'b0},
    '{MAT_UNIT, 16'h8000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 24'h7FFFFF, 24'h000000, 1'b0},
    // quotient truncates toward zero on both signs
    '{MAT_UNIT, 16'h012C, 16'hFED4, 16'h0007, 1'b0, 1'b1, 24'h002ADB, 24'hFFD525, 1'b0},
    '{MAT_UNIT, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 1'b1, 24'h000000, 24'h000000, 1'b0},
    '{MAT_UNIT, 16'hAAAA, 16'h5555, 16'h0300, 1'b1, 1'b0, 24'h0, 24'h0, 1'b0},
    // extreme coefficients, tiny depth
    '{MAT_SATURATE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0},
    '{MAT_SATURATE, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 24'h0, 24'h0, 1'b0},
    '{MAT_SATURATE, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0},
    '{MAT_SATURATE, 16'h0000, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0},
    '{MAT_SATURATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 24'h0, 24'h0, 1'b0},
    // camera-like matrix, in front of and behind the camera
    '{MAT_CAMERA, 16'h0100, 16'h0100, 16'h0A00, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0},
    '{MAT_CAMERA, 16'hF600, 16'h0500, 16'h1900, 1'b1, 1'b0, 24'h0, 24'h0, 1'b0},
    '{MAT_CAMERA, 16'h0200, 16'h0300, 16'hF000, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IW-1:0]        cfg_index = '0;
  logic [CFG_DW-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [15:0]       in_point_x = '0;
  logic signed [15:0]       in_point_y = '0;
  logic signed [15:0]       in_point_z = '0;
  logic                     in_last_point = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [23:0]       out_pixel_u;
  logic signed [23:0]       out_pixel_v;
  logic                     out_depth_zero;
  logic                     out_last_result;

  // hand-typed expectation travels with the point it belongs to
  logic                     typed_now = 1'b0;
  pix_res_t                 typed_want = '0;

  logic [CFG_DW-1:0]        model_regs [NREGS] = '{default: '0};
  pix_res_t                 pending_pixels [$];
  int                       gap_pct = 0;
  int                       stall_pct = 0;
  int                       n_points = 0;
  int                       n_results = 0;
  int                       n_zero = 0;
  int                       n_clipped = 0;
  int                       n_matrices = 0;
  int                       n_fail = 0;

  lidar_point_to_image_projection dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_u     (out_pixel_u),
    .out_pixel_v     (out_pixel_v),
    .out_depth_zero  (out_depth_zero),
    .out_last_result (out_last_result)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // one matrix row against (x, y, z, 1), result in Q.24
  function automatic longint row_dot(logic [CFG_DW-1:0] lo, logic [CFG_DW-1:0] hi,
                                     longint x, longint y, longint z);
    return longint'($signed(lo[31:0])) * x + longint'($signed(lo[63:32])) * y
         + longint'($signed(hi[31:0])) * z + longint'($signed(hi[63:32])) * 256;
  endfunction

  function automatic logic [23:0] to_pixel(longint num, longint den);
    longint q;
    q = (num * 256) / den;
    if (q > PIX_HI) q = PIX_HI;
    if (q < PIX_LO) q = PIX_LO;
    return q[23:0];
  endfunction

  function automatic pix_res_t project_point(logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z, logic last);
    longint   sx, sy, sz, a, b, c;
    pix_res_t r;
    sx = longint'($signed(x));
    sy = longint'($signed(y));
    sz = longint'($signed(z));
    a = row_dot(model_regs[REG_R0_C01], model_regs[REG_R0_C23], sx, sy, sz);
    b = row_dot(model_regs[REG_R1_C01], model_regs[REG_R1_C23], sx, sy, sz);
    c = row_dot(model_regs[REG_R2_C01], model_regs[REG_R2_C23], sx, sy, sz);
    r.last = last;
    if (c == 0) begin
      r.u    = '0;
      r.v    = '0;
      r.zero = 1'b1;
    end else begin
      r.u    = to_pixel(a, c);
      r.v    = to_pixel(b, c);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- random helpers

  function automatic logic [31:0] rand_span(int unsigned m);
    return 32'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // write all six coefficient registers plus the unused indexes
  task automatic load_matrix(input matrix_kind_t kind);
    logic [31:0]       k [3][4];
    logic [CFG_DW-1:0] regs_new [NREGS];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        k[r][c] = '0;
    case (kind)
      MAT_UNIT: begin
        k[0][0] = ONE_Q16;
        k[1][1] = ONE_Q16;
        k[2][2] = ONE_Q16;
      end
      MAT_SATURATE: begin
        for (int c = 0; c < 4; c++) begin
          k[0][c] = 32'h7FFF_FFFF;
          k[1][c] = 32'h8000_0000;
        end
        k[2][0] = 32'h0000_0001;
      end
      MAT_CAMERA: begin
        // focal lengths, principal point, small rotation and translation
        k[0][0] = {16'($urandom_range(100, 2000)), 16'($urandom)};
        k[0][1] = rand_span(1 << 15);
        k[0][2] = {16'($urandom_range(0, 1920)), 16'h0000};
        k[0][3] = rand_span(1 << 22);
        k[1][0] = rand_span(1 << 15);
        k[1][1] = {16'($urandom_range(100, 2000)), 16'($urandom)};
        k[1][2] = {16'($urandom_range(0, 1080)), 16'h0000};
        k[1][3] = rand_span(1 << 22);
        k[2][0] = rand_span(1 << 12);
        k[2][1] = rand_span(1 << 12);
        k[2][2] = ONE_Q16 + rand_span(1 << 14);
        k[2][3] = rand_span(1 << 20);
      end
      MAT_EXTREME: begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 4; c++)
            case ($urandom_range(0, 3))
              0:       k[r][c] = 32'h7FFF_FFFF;
              1:       k[r][c] = 32'h8000_0000;
              2:       k[r][c] = 32'hFFFF_FFFF;
              default: k[r][c] = 32'h0000_0001;
            endcase
      end
      MAT_FLAT_DEPTH: begin
        // depth follows z alone, so z == 0 gives a zero depth
        for (int r = 0; r < 2; r++)
          for (int c = 0; c < 4; c++)
            k[r][c] = $urandom;
        k[2][2] = $urandom | 32'h1;
      end
      MAT_RANDOM: begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 4; c++)
            k[r][c] = $urandom;
      end
      default: ;
    endcase
    regs_new[REG_R0_C01] = {k[0][1], k[0][0]};
    regs_new[REG_R0_C23] = {k[0][3], k[0][2]};
    regs_new[REG_R1_C01] = {k[1][1], k[1][0]};
    regs_new[REG_R1_C23] = {k[1][3], k[1][2]};
    regs_new[REG_R2_C01] = {k[2][1], k[2][0]};
    regs_new[REG_R2_C23] = {k[2][3], k[2][2]};
    for (int i = 0; i < (1 << CFG_IW); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_wdata <= (i < NREGS) ? regs_new[i] : {$urandom, $urandom};
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    n_matrices++;
  endtask

  // present one point and hold it until the transfer; called at a falling edge
  task automatic push_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic last,
                            input logic typed, input pix_res_t want);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_point_z    <= z;
    in_last_point <= last;
    typed_now     <= typed;
    typed_want    <= want;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding pixel
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // result side back-pressure in random bursts, set by stall_pct
  initial begin : sink_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- scoreboard

  always @(posedge clk) begin : scoreboard
    pix_res_t got;
    pix_res_t want;
    if (rst_n) begin
      // result transfer: compare against the oldest outstanding pixel
      if (out_valid === 1'b1 && out_ready) begin
        got = {out_pixel_u, out_pixel_v, out_depth_zero, out_last_result};
        n_results++;
        if (got.zero) n_zero++;
        if (got.u == PIX_MAX || got.u == PIX_MIN || got.v == PIX_MAX || got.v == PIX_MIN)
          n_clipped++;
        if (pending_pixels.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected result u=%h v=%h dz=%b last=%b", $realtime,
                     got.u, got.v, got.zero, got.last);
        end else begin
          want = pending_pixels.pop_front();
          if (got.u !== want.u || got.v !== want.v || got.zero !== want.zero ||
              got.last !== want.last) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: mismatch exp u=%h v=%h dz=%b last=%b, got u=%h v=%h dz=%b last=%b",
                       $realtime, want.u, want.v, want.zero, want.last,
                       got.u, got.v, got.zero, got.last);
          end
        end
      end
      // point transfer: queue what it should produce
      if (in_valid && in_ready === 1'b1) begin
        pending_pixels.push_back(typed_now ? typed_want :
            project_point(in_point_x, in_point_y, in_point_z, in_last_point));
        n_points++;
      end
      // mirror register writes; out-of-range indexes are dropped
      if (cfg_we && cfg_index < NREGS) model_regs[cfg_index] = cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    matrix_kind_t cur_mat;
    pix_res_t     want;
    logic [15:0]  px, py, pz;
    logic         plast;
    int           sel;
    int           wf_pct;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, reloading coefficients when the set changes
    cur_mat   = MAT_RESET;
    gap_pct   = 25;
    stall_pct = 25;
    for (int i = 0; i < NDIR; i++) begin
      if (DIR_ROWS[i].mat != cur_mat) begin
        wait_drained();
        load_matrix(DIR_ROWS[i].mat);
        cur_mat = DIR_ROWS[i].mat;
      end
      want = {DIR_ROWS[i].u, DIR_ROWS[i].v, DIR_ROWS[i].dz, DIR_ROWS[i].last};
      push_point(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z, DIR_ROWS[i].last,
                 DIR_ROWS[i].typed, want);
    end

    // random phases, one coefficient set each; the last one runs flat out
    for (int p = 0; p < NPHASE; p++) begin
      wait_drained();
      gap_pct   = (p == NPHASE - 1) ? 0 : pick_idle_pct();
      stall_pct = (p == NPHASE - 1) ? 0 : pick_idle_pct();
      load_matrix(PHASE_KINDS[p]);
      wf_pct = (PHASE_KINDS[p] == MAT_CAMERA) ? 92 : 40;
      repeat (PHASE_POINTS) begin
        sel   = $urandom_range(0, 99);
        px    = 16'($urandom);
        py    = 16'($urandom);
        pz    = 16'($urandom);
        plast = ($urandom_range(0, 7) == 0);
        if (sel < 8) begin
          pz = '0;
        end else if (sel < 18) begin
          px = pick_edge();
          py = pick_edge();
          pz = pick_edge();
        end else if (sel < wf_pct) begin
          // plausible scene point within 50 m laterally, in front of the sensor
          px = 16'(rand_span(12800));
          py = 16'(rand_span(12800));
          pz = 16'($urandom_range(256, 32767));
        end
        push_point(px, py, pz, plast, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Projected %0d points through %0d coefficient sets, reset and extremes included.",
             n_points, n_matrices);
    $display("Checked %0d pixels: %0d with zero depth, %0d clipped at the pixel range.",
             n_results, n_zero, n_clipped);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lpi_pkg.sv
design/lpi_front.sv
design/lpi_queue.sv
design/lpi_back.sv
design/lidar_point_to_image_projection.sv
dv/lidar_point_to_image_projection_tb.sv
